[rtl/bwm_pkg.sv]
package bwm_pkg;

  localparam int unsigned TsW    = 64;
  localparam int unsigned HashW  = 64;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CountW = 64;
  localparam int unsigned RateW  = 64;
  localparam int unsigned WidthW = 41;

  localparam logic [WidthW-1:0] WidthReset = WidthW'(100 * 1000 * 1000);

  localparam logic [HashW-1:0] MarkerA = 64'hFEED_CAFE_DEAD_BEEF;
  localparam logic [HashW-1:0] MarkerB = 64'hFFFF_FFFF_FFFF_F106;

  // 8 bits/byte * 1e9 ns/s = 5^9 * 2^12: nine times-five steps, then a shift
  localparam int unsigned MulSteps  = 9;
  localparam int unsigned RateShift = 12;
  localparam int unsigned OddW      = 21;  // 5^9 < 2^21
  localparam int unsigned MulW      = CountW + OddW;

  localparam int unsigned DivSteps = RateW;
  localparam int unsigned CntW     = $clog2(DivSteps);

endpackage

[rtl/bwm_in_if.sv]
interface bwm_in_if;
  logic                         valid;
  logic                         ready;
  logic [bwm_pkg::TsW-1:0]      timestamp;
  logic [bwm_pkg::HashW-1:0]    flow_hash;
  logic [bwm_pkg::LenW-1:0]     packet_length;
  logic                         first_of_run;
  logic [bwm_pkg::TsW-1:0]      seed_timestamp;

  modport source (
    output valid, timestamp, flow_hash, packet_length, first_of_run, seed_timestamp,
    input  ready
  );
  modport sink (
    input  valid, timestamp, flow_hash, packet_length, first_of_run, seed_timestamp,
    output ready
  );
endinterface

[rtl/bwm_out_if.sv]
interface bwm_out_if;
  logic                         valid;
  logic                         ready;
  logic [bwm_pkg::TsW-1:0]      point_timestamp;
  logic [bwm_pkg::CountW-1:0]   class0_bytes;
  logic [bwm_pkg::RateW-1:0]    class0_rate;
  logic [bwm_pkg::RateW-1:0]    class1_rate;
  logic                         last;

  modport source (
    output valid, point_timestamp, class0_bytes, class0_rate, class1_rate, last,
    input  ready
  );
  modport sink (
    input  valid, point_timestamp, class0_bytes, class0_rate, class1_rate, last,
    output ready
  );
endinterface

[rtl/windowed_two_class_bandwidth_meter_core.sv]
// Two-class bandwidth meter over time windows.
// in_i takes one packet record per transfer (valid/ready). Class 1 is a packet whose
// flow hash matches one of two marker values; all others are class 0. The packet
// length is added to its class counter in the transfer cycle.
// In the next cycle the window test runs. A packet that does not close the window
// then sends the block back to idle, and the next record waits until then.
// A packet that closes the window starts the rate unit, shared by both classes:
// times-five steps, a range check, then restoring division, one quotient bit per
// cycle. The division is skipped when the rate saturates.
// A big gap gives two points; the second shows in the cycle after the first is taken.
// in_i stays not ready from the transfer until the last point of that packet
// is taken. A stalled out_o holds its point and the block waits.
// The window width register is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while idle, as the block does not enforce this. Reset clears window
// start, previous timestamp and both counters, loads 100 ms width, and is then ready.
module windowed_two_class_bandwidth_meter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bwm_pkg::WidthW-1:0]    cfg_wdata_i,
  bwm_in_if.sink                        in_i,
  bwm_out_if.source                     out_o
);

  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StMul,
    StChk,
    StDiv,
    StEmit
  } state_e;

  state_e                          state_q;
  logic [bwm_pkg::WidthW-1:0]      width_q;
  logic [bwm_pkg::TsW-1:0]         ts_q;
  logic [bwm_pkg::TsW-1:0]         ws_q;
  logic [bwm_pkg::TsW-1:0]         prev_q;
  logic [bwm_pkg::CountW-1:0]      c0_q;
  logic [bwm_pkg::CountW-1:0]      c1_q;
  logic [bwm_pkg::TsW-1:0]         elapsed_q;
  logic                            big_gap_q;
  logic                            sel_q;
  logic [bwm_pkg::CntW-1:0]        cnt_q;
  logic [bwm_pkg::MulW-1:0]        mul_q;
  logic [bwm_pkg::RateW-1:0]       rem_q;
  logic [bwm_pkg::RateW-1:0]       lo_q;
  logic [bwm_pkg::RateW-1:0]       quo_q;
  logic [bwm_pkg::RateW-1:0]       r0_q;
  logic [bwm_pkg::RateW-1:0]       r1_q;
  logic [bwm_pkg::TsW-1:0]         out_ts_q;
  logic                            out_last_q;

  logic                            in_fire;
  logic                            out_fire;
  logic                            is_cls1;
  logic [bwm_pkg::TsW-1:0]         ws_base;
  logic [bwm_pkg::TsW-1:0]         prev_base;
  logic [bwm_pkg::CountW-1:0]      c0_base;
  logic [bwm_pkg::CountW-1:0]      c1_base;
  logic [bwm_pkg::CountW-1:0]      len_ext;
  logic [bwm_pkg::TsW-1:0]         diff_ws;
  logic [bwm_pkg::TsW-1:0]         diff_prev;
  logic [bwm_pkg::TsW-1:0]         width_ext;
  logic                            closes;
  logic                            big_gap;
  logic [bwm_pkg::TsW-1:0]         div_hi;
  logic [bwm_pkg::RateW-1:0]       div_lo;
  logic [bwm_pkg::RateW:0]         r_shift;
  logic [bwm_pkg::RateW+1:0]       r_sub;
  logic                            take;
  logic [bwm_pkg::RateW-1:0]       rem_next;
  logic                            q_done;
  logic [bwm_pkg::RateW-1:0]       q_val;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  assign in_i.ready            = (state_q == StIdle);
  assign out_o.valid           = (state_q == StEmit);
  assign out_o.point_timestamp = out_ts_q;
  assign out_o.class0_bytes    = c0_q;
  assign out_o.class0_rate     = r0_q;
  assign out_o.class1_rate     = r1_q;
  assign out_o.last            = out_last_q;

  always_comb begin
    is_cls1   = (in_i.flow_hash == bwm_pkg::MarkerA) || (in_i.flow_hash == bwm_pkg::MarkerB);
    ws_base   = in_i.first_of_run ? in_i.timestamp : ws_q;
    prev_base = in_i.first_of_run ? in_i.seed_timestamp : prev_q;
    c0_base   = in_i.first_of_run ? '0 : c0_q;
    c1_base   = in_i.first_of_run ? '0 : c1_q;
    len_ext   = bwm_pkg::CountW'(in_i.packet_length);

    width_ext = bwm_pkg::TsW'(width_q);
    diff_ws   = ts_q - ws_q;
    diff_prev = ts_q - prev_q;
    closes    = (ts_q > ws_q) && (diff_ws > width_ext);
    big_gap   = (ts_q > prev_q) && (diff_prev > width_ext);

    // dividend = product << RateShift, split into high and low words
    div_hi = bwm_pkg::TsW'(mul_q[bwm_pkg::MulW-1:bwm_pkg::RateW-bwm_pkg::RateShift]);
    div_lo = {mul_q[bwm_pkg::RateW-bwm_pkg::RateShift-1:0], bwm_pkg::RateShift'(0)};

    r_shift  = {rem_q, lo_q[bwm_pkg::RateW-1]};
    r_sub    = {1'b0, r_shift} - {2'b00, elapsed_q};
    take     = !r_sub[bwm_pkg::RateW+1];
    rem_next = take ? r_sub[bwm_pkg::RateW-1:0] : r_shift[bwm_pkg::RateW-1:0];

    q_done = 1'b0;
    q_val  = {quo_q[bwm_pkg::RateW-2:0], take};
    if (state_q == StChk && div_hi >= elapsed_q) begin
      q_done = 1'b1;
      q_val  = '1;
    end else if (state_q == StDiv && cnt_q == bwm_pkg::CntW'(bwm_pkg::DivSteps - 1)) begin
      q_done = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      width_q    <= bwm_pkg::WidthReset;
      ts_q       <= '0;
      ws_q       <= '0;
      prev_q     <= '0;
      c0_q       <= '0;
      c1_q       <= '0;
      elapsed_q  <= '0;
      sel_q      <= 1'b0;
      cnt_q      <= '0;
      mul_q      <= '0;
      rem_q      <= '0;
      lo_q       <= '0;
      quo_q      <= '0;
      r0_q       <= '0;
      r1_q       <= '0;
      out_ts_q   <= '0;
      big_gap_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            ts_q    <= in_i.timestamp;
            ws_q    <= ws_base;
            prev_q  <= prev_base;
            c0_q    <= is_cls1 ? c0_base : c0_base + len_ext;
            c1_q    <= is_cls1 ? c1_base + len_ext : c1_base;
            state_q <= StEval;
          end
        end
        StEval: begin
          if (closes) begin
            elapsed_q <= diff_ws;
            big_gap_q <= big_gap;
            sel_q     <= 1'b0;
            mul_q     <= bwm_pkg::MulW'(c0_q);
            cnt_q     <= '0;
            state_q   <= StMul;
          end else begin
            prev_q  <= ts_q;
            state_q <= StIdle;
          end
        end
        StMul: begin
          mul_q <= mul_q + {mul_q[bwm_pkg::MulW-3:0], 2'b00};
          if (cnt_q == bwm_pkg::CntW'(bwm_pkg::MulSteps - 1)) begin
            cnt_q   <= '0;
            state_q <= StChk;
          end else begin
            cnt_q <= cnt_q + bwm_pkg::CntW'(1);
          end
        end
        StChk: begin
          // hi < elapsed here unless saturated, so it fits the remainder
          rem_q <= div_hi;
          lo_q  <= div_lo;
          quo_q <= '0;
          cnt_q <= '0;
          if (!q_done) begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          rem_q <= rem_next;
          lo_q  <= {lo_q[bwm_pkg::RateW-2:0], 1'b0};
          quo_q <= q_val;
          cnt_q <= cnt_q + bwm_pkg::CntW'(1);
        end
        StEmit: begin
          if (out_fire) begin
            if (!out_last_q) begin
              out_ts_q   <= ts_q;
              out_last_q <= 1'b1;
            end else begin
              ws_q    <= ts_q;
              prev_q  <= ts_q;
              c0_q    <= '0;
              c1_q    <= '0;
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
      if (q_done) begin
        cnt_q <= '0;
        if (!sel_q) begin
          r0_q    <= q_val;
          sel_q   <= 1'b1;
          mul_q   <= bwm_pkg::MulW'(c1_q);
          state_q <= StMul;
        end else begin
          r1_q       <= q_val;
          out_ts_q   <= big_gap_q ? prev_q : ts_q;
          out_last_q <= !big_gap_q;
          state_q    <= StEmit;
        end
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a point is pending");

  a_second_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_o.last) |=> (out_o.valid && out_o.last))
    else $error("first of two points not followed by the final one");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.last) |=> (in_i.ready && c0_q == '0 && c1_q == '0 && ws_q == prev_q))
    else $error("window not restarted after the final point");

  a_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.first_of_run) |=> (ws_q == $past(in_i.timestamp)))
    else $error("run start did not seed the window start");

  a_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul || state_q == StChk || state_q == StDiv) |-> (elapsed_q != '0))
    else $error("rate unit running with zero elapsed time");

endmodule
